// ===== rtl/xmbr_pkg.sv =====
package xmbr_pkg;

    // Line control bytes
    localparam logic [7:0] SOH_B       = 8'h01;
    localparam logic [7:0] EOT_B       = 8'h04;
    localparam logic [7:0] ACK_B       = 8'h06;
    localparam logic [7:0] NAK_B       = 8'h15;
    localparam logic [7:0] CAN_B       = 8'h18;
    localparam logic [7:0] CRC_START_B = 8'h43;  // 'C'

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_USE_CRC     = 1'b0;
    localparam logic CFG_ERROR_LIMIT = 1'b1;

    // Status codes
    localparam logic [2:0] ST_RECEIVING = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_NO_EOT2   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_NUM,
        PH_COMP,
        PH_DATA,
        PH_CHECK,
        PH_EOT,
        PH_END
    } phase_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       block_end;
        logic       block_commit;
        logic [2:0] status;
    } out_word_t;

    // CRC-16, poly 0x1021, MSB first, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/xmodem_block_receiver.sv =====
// XMODEM block receiver, one line event per input word.
// A result word is registered into the output register, or the skid entry while that is full.
// Throughput: one input word per cycle while the skid entry is empty; the CRC-16 byte update
// and the verdict compare are combinational logic ahead of the result register.
// A two-deep result buffer (output register plus skid) keeps s_ready high while one result waits.
// Reset (aresetn low, synchronous): idle before start, counters cleared, use_crc=1, limit=10.
module xmodem_block_receiver
    import xmbr_pkg::*;
#(
    parameter int DATA_BYTES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data
);

    localparam int POS_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DATA_BYTES - 1);

    // Configuration
    logic       use_crc_reg;
    logic [7:0] error_limit_reg;

    // Protocol state
    phase_t     phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic       chk_hi_reg, chk_hi_next;     // first CRC byte already seen
    logic [7:0] sum_reg, sum_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0] blk_num_reg, blk_num_next;
    logic [7:0] blk_cmp_reg, blk_cmp_next;
    logic [7:0] first_chk_reg, first_chk_next;
    logic [7:0] last_good_reg, last_good_next;
    logic [7:0] err_cnt_reg, err_cnt_next;

    // Result buffer
    logic       out_valid_reg;
    out_word_t  out_word_reg;
    logic       skid_valid_reg;
    out_word_t  skid_word_reg;

    logic       res_has;
    out_word_t  res;
    logic       s_fire;
    logic       m_pop;

    // Verdict terms
    logic       check_ok;
    logic       good;
    logic       fresh;
    logic [7:0] err_after;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;
    assign m_pop   = out_valid_reg && m_ready;

    // Check compare for a final check byte
    always_comb begin
        if (use_crc_reg) begin
            check_ok = (first_chk_reg == crc_reg[7:0]) && (s_data.rx_byte == crc_reg[15:8]);
        end else begin
            check_ok = (s_data.rx_byte == sum_reg);
        end
        good  = check_ok && (blk_num_reg == (COUNT_MAX - blk_cmp_reg));
        fresh = good && (blk_num_reg == (last_good_reg + 8'd1));
        if (fresh) begin
            err_after = '0;
        end else if (err_cnt_reg != COUNT_MAX) begin
            err_after = err_cnt_reg + 8'd1;
        end else begin
            err_after = err_cnt_reg;
        end
    end

    // Next state and result for the word at the input
    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        chk_hi_next    = chk_hi_reg;
        sum_next       = sum_reg;
        crc_next       = crc_reg;
        blk_num_next   = blk_num_reg;
        blk_cmp_next   = blk_cmp_reg;
        first_chk_next = first_chk_reg;
        last_good_next = last_good_reg;
        err_cnt_next   = err_cnt_reg;
        res_has        = 1'b0;
        res            = '0;

        if (s_data.opcode == OP_START) begin
            // start (or restart) of a transfer
            phase_next     = PH_WAIT;
            pos_next       = '0;
            chk_hi_next    = 1'b0;
            sum_next       = '0;
            crc_next       = '0;
            err_cnt_next   = '0;
            last_good_next = '0;
            res_has          = 1'b1;
            res.reply_valid  = 1'b1;
            res.reply_byte   = use_crc_reg ? CRC_START_B : NAK_B;
        end else begin
            case (phase_reg)
                PH_WAIT: begin
                    if (s_data.rx_byte == SOH_B) begin
                        phase_next = PH_NUM;
                    end else if (s_data.rx_byte == CAN_B) begin
                        phase_next = PH_END;
                        res_has    = 1'b1;
                        res.status = ST_CANCELLED;
                    end else if (s_data.rx_byte == EOT_B) begin
                        phase_next      = PH_EOT;
                        res_has         = 1'b1;
                        res.reply_valid = 1'b1;
                        res.reply_byte  = NAK_B;
                    end
                end
                PH_NUM: begin
                    blk_num_next = s_data.rx_byte;
                    phase_next   = PH_COMP;
                end
                PH_COMP: begin
                    blk_cmp_next = s_data.rx_byte;
                    pos_next     = '0;
                    chk_hi_next  = 1'b0;
                    sum_next     = '0;
                    crc_next     = '0;
                    phase_next   = PH_DATA;
                end
                PH_DATA: begin
                    sum_next = sum_reg + s_data.rx_byte;
                    crc_next = crc16_byte(crc_reg, s_data.rx_byte);
                    if (pos_reg == POS_LAST) begin
                        pos_next    = '0;
                        chk_hi_next = 1'b0;
                        phase_next  = PH_CHECK;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                    res_has        = 1'b1;
                    res.data_valid = 1'b1;
                    res.data_byte  = s_data.rx_byte;
                end
                PH_CHECK: begin
                    if (use_crc_reg && !chk_hi_reg) begin
                        first_chk_next = s_data.rx_byte;
                        chk_hi_next    = 1'b1;
                    end else begin
                        if (fresh) begin
                            last_good_next = blk_num_reg;
                        end
                        err_cnt_next  = err_after;
                        chk_hi_next   = 1'b0;
                        pos_next      = '0;
                        phase_next    = PH_WAIT;
                        res_has       = 1'b1;
                        res.block_end = 1'b1;
                        if (err_after < error_limit_reg) begin
                            res.reply_valid  = 1'b1;
                            res.reply_byte   = good ? ACK_B : NAK_B;
                            res.block_commit = fresh;
                        end else begin
                            res.status = ST_TOO_MANY;
                        end
                    end
                end
                PH_EOT: begin
                    phase_next = PH_END;
                    res_has    = 1'b1;
                    if (s_data.rx_byte == EOT_B) begin
                        res.reply_valid = 1'b1;
                        res.reply_byte  = ACK_B;
                        res.status      = ST_DONE;
                    end else begin
                        res.status = ST_NO_EOT2;
                    end
                end
                default: begin
                    // idle before start, or transfer over: byte ignored
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_crc_reg     <= 1'b1;
            error_limit_reg <= 8'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_USE_CRC:     use_crc_reg     <= cfg_wdata[0];
                CFG_ERROR_LIMIT: error_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Protocol state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            chk_hi_reg    <= 1'b0;
            sum_reg       <= '0;
            crc_reg       <= '0;
            blk_num_reg   <= '0;
            blk_cmp_reg   <= '0;
            first_chk_reg <= '0;
            last_good_reg <= '0;
            err_cnt_reg   <= '0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            chk_hi_reg    <= chk_hi_next;
            sum_reg       <= sum_next;
            crc_reg       <= crc_next;
            blk_num_reg   <= blk_num_next;
            blk_cmp_reg   <= blk_cmp_next;
            first_chk_reg <= first_chk_next;
            last_good_reg <= last_good_next;
            err_cnt_reg   <= err_cnt_next;
        end
    end

    // Result buffer: output register backed by one skid entry.
    // The input stalls only while the skid entry is occupied.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_fire && res_has) begin
            if (!out_valid_reg || m_pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_pop) begin
                out_word_reg <= skid_word_reg;
            end
        end else if (s_fire && res_has) begin
            if (!out_valid_reg || m_pop) begin
                out_word_reg <= res;
            end else begin
                skid_word_reg <= res;
            end
        end
    end

`ifndef SYNTHESIS
    // skid entry only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    // draining the output while the skid holds a word refills the output
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word lost on drain");

    // a data byte always yields a result word
    a_data_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.opcode == OP_BYTE && phase_reg == PH_DATA) |=> out_valid_reg)
        else $error("data byte gave no result");

    // commit only on a verdict word
    a_commit_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!out_word_reg.block_commit || out_word_reg.block_end))
        else $error("commit without block end");
`endif

endmodule
